### hdl/vlfd_pkg.sv
package vlfd_pkg;

    localparam int MAX_LETTERS_DEFAULT = 126;
    localparam int VALUE_BITS_DEFAULT  = 64;
    localparam int NUM_SLOTS           = 4;
    localparam int END_SLOT            = 3;
    localparam logic [7:0] LETTER_BASE = 8'd96;
    localparam logic [6:0] SHIFT_MAX   = 7'd127;

    typedef enum logic [1:0] {
        OP_UNSIGNED = 2'd0,
        OP_SIGNED   = 2'd1,
        OP_LETTERS  = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_UNSIGNED = 2'd0,
        KIND_SIGNED   = 2'd1,
        KIND_LETTER   = 2'd2,
        KIND_END      = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] letter;
        logic       last_flag;
        logic       overflow;
    } res_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        res_t [NUM_SLOTS-1:0] slot;
        logic [63:0]          number;
    } bundle_t;

endpackage

### hdl/varint_and_letter_field_decoder.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    opcode[1:0], data_byte[7:0]
// output    out        out_valid / out_ready  kind[1:0], number[63:0], letter[7:0],
//                                             last_flag, overflow
//
// A byte is decoded in the cycle it is accepted and its results are registered.
// A byte that gives no result or one result leaves room for the next byte in the
// following cycle if out_ready is set, so number fields run at one byte per cycle.
// A letter pair can give up to four results, drained one per output beat from the
// result register; input is held off until its last beat is taken.
// Reset clears the field state and empties the result register.
module varint_and_letter_field_decoder #(
    parameter int MAX_LETTERS = vlfd_pkg::MAX_LETTERS_DEFAULT,
    parameter int VALUE_BITS  = vlfd_pkg::VALUE_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [63:0] number,
    output logic [7:0]  letter,
    output logic        last_flag,
    output logic        overflow
);

    vlfd_pkg::bundle_t bundle;
    logic accept;

    assign accept = in_valid && in_ready;

    vlfd_core #(
        .MAX_LETTERS(MAX_LETTERS),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .opcode   (opcode),
        .data_byte(data_byte),
        .bundle   (bundle)
    );

    vlfd_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .bundle   (bundle),
        .free     (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind     (kind),
        .number   (number),
        .letter   (letter),
        .last_flag(last_flag),
        .overflow (overflow)
    );

endmodule

### hdl/vlfd_core.sv
module vlfd_core #(
    parameter int MAX_LETTERS = vlfd_pkg::MAX_LETTERS_DEFAULT,
    parameter int VALUE_BITS  = vlfd_pkg::VALUE_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        opcode,
    input  logic [7:0]        data_byte,
    output vlfd_pkg::bundle_t bundle
);

    localparam logic [63:0] VMASK   = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam logic [7:0]  MAXL    = 8'(MAX_LETTERS);
    localparam logic [7:0]  VBITS   = 8'(VALUE_BITS);

    logic [63:0]         acc_reg, acc_next;
    logic [6:0]          shift_reg, shift_next;
    logic                in_field_reg, in_field_next;
    vlfd_pkg::kind_t     kind_reg, kind_next;
    logic                neg_reg, neg_next;
    logic [7:0]          pend_reg, pend_next;
    logic                have_reg, have_next;
    logic                null_reg, null_next;
    logic [7:0]          count_reg, count_next;
    logic                ovf_reg, ovf_next;

    always_comb
    begin
        logic [15:0] pair;
        logic [4:0]  code;
        logic [6:0]  chunk;
        logic [7:0]  nbits;
        logic [7:0]  ssum;
        logic [63:0] v;
        logic        done;

        acc_next      = acc_reg;
        shift_next    = shift_reg;
        in_field_next = in_field_reg;
        kind_next     = kind_reg;
        neg_next      = neg_reg;
        pend_next     = pend_reg;
        have_next     = have_reg;
        null_next     = null_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        bundle        = '0;
        pair          = '0;
        code          = '0;
        chunk         = '0;
        nbits         = 8'd7;
        ssum          = '0;
        v             = '0;
        done          = 1'b0;

        if (!in_field_reg)
        begin
            acc_next      = '0;
            shift_next    = '0;
            neg_next      = 1'b0;
            pend_next     = '0;
            have_next     = 1'b0;
            null_next     = 1'b0;
            count_next    = '0;
            ovf_next      = 1'b0;
            in_field_next = 1'b1;
            unique case (vlfd_pkg::op_t'(opcode))
                vlfd_pkg::OP_SIGNED:  kind_next = vlfd_pkg::KIND_SIGNED;
                vlfd_pkg::OP_LETTERS: kind_next = vlfd_pkg::KIND_LETTER;
                default:              kind_next = vlfd_pkg::KIND_UNSIGNED;
            endcase
        end

        if (kind_next == vlfd_pkg::KIND_LETTER)
        begin
            if (!have_next)
            begin
                pend_next = data_byte;
                have_next = 1'b1;
            end
            else
            begin
                pair      = {pend_next, data_byte};
                have_next = 1'b0;
                for (int j = 0; j < 3; j++)
                begin
                    code = pair[11-5*j +: 5];
                    if (!null_next)
                    begin
                        if (code == 5'd0 && j != 0)
                        begin
                            null_next = 1'b1;
                        end
                        else if (count_next < MAXL)
                        begin
                            count_next                 = count_next + 8'd1;
                            bundle.mask[j]             = 1'b1;
                            bundle.slot[j].kind        = vlfd_pkg::KIND_LETTER;
                            bundle.slot[j].letter      = {3'b000, code} + vlfd_pkg::LETTER_BASE;
                            bundle.slot[j].last_flag   = 1'b0;
                            bundle.slot[j].overflow    = ovf_next;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                if (!pair[0])
                begin
                    bundle.mask[vlfd_pkg::END_SLOT]           = 1'b1;
                    bundle.slot[vlfd_pkg::END_SLOT].kind      = vlfd_pkg::KIND_END;
                    bundle.slot[vlfd_pkg::END_SLOT].letter    = '0;
                    bundle.slot[vlfd_pkg::END_SLOT].last_flag = 1'b1;
                    bundle.slot[vlfd_pkg::END_SLOT].overflow  = ovf_next;
                    done = 1'b1;
                end
            end
        end
        else
        begin
            if (!in_field_reg && kind_next == vlfd_pkg::KIND_SIGNED)
            begin
                neg_next = data_byte[7];
                chunk    = {1'b0, data_byte[6:1]};
                nbits    = 8'd6;
            end
            else
            begin
                chunk = data_byte[7:1];
            end
            for (int p = 0; p < 7; p++)
            begin
                if (chunk[p] && ({1'b0, shift_next} + 8'(p) >= VBITS))
                begin
                    ovf_next = 1'b1;
                end
            end
            acc_next   = acc_next | (({57'd0, chunk} << shift_next) & VMASK);
            ssum       = {1'b0, shift_next} + nbits;
            shift_next = (ssum > {1'b0, vlfd_pkg::SHIFT_MAX}) ? vlfd_pkg::SHIFT_MAX : ssum[6:0];
            if (!data_byte[0])
            begin
                v = acc_next & VMASK;
                if (kind_next == vlfd_pkg::KIND_SIGNED)
                begin
                    if (neg_next)
                    begin
                        v = (64'd0 - v) & VMASK;
                    end
                    if (v[VALUE_BITS-1])
                    begin
                        v = v | ~VMASK;
                    end
                end
                bundle.mask[0]           = 1'b1;
                bundle.slot[0].kind      = kind_next;
                bundle.slot[0].letter    = '0;
                bundle.slot[0].last_flag = 1'b1;
                bundle.slot[0].overflow  = ovf_next;
                bundle.number            = v;
                done = 1'b1;
            end
        end

        if (done)
        begin
            acc_next      = '0;
            shift_next    = '0;
            in_field_next = 1'b0;
            kind_next     = vlfd_pkg::KIND_UNSIGNED;
            neg_next      = 1'b0;
            pend_next     = '0;
            have_next     = 1'b0;
            null_next     = 1'b0;
            count_next    = '0;
            ovf_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            shift_reg    <= '0;
            in_field_reg <= 1'b0;
            kind_reg     <= vlfd_pkg::KIND_UNSIGNED;
            neg_reg      <= 1'b0;
            pend_reg     <= '0;
            have_reg     <= 1'b0;
            null_reg     <= 1'b0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg      <= acc_next;
            shift_reg    <= shift_next;
            in_field_reg <= in_field_next;
            kind_reg     <= kind_next;
            neg_reg      <= neg_next;
            pend_reg     <= pend_next;
            have_reg     <= have_next;
            null_reg     <= null_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

### hdl/vlfd_out_queue.sv
module vlfd_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  vlfd_pkg::bundle_t bundle,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        kind,
    output logic [63:0]       number,
    output logic [7:0]        letter,
    output logic              last_flag,
    output logic              overflow
);

    logic [vlfd_pkg::NUM_SLOTS-1:0] mask_reg, mask_next;
    vlfd_pkg::res_t [vlfd_pkg::NUM_SLOTS-1:0] slot_reg;
    logic [63:0] number_reg;
    logic [vlfd_pkg::NUM_SLOTS-1:0] sel;
    vlfd_pkg::res_t cur;
    logic beat;

    assign sel       = mask_reg & (~mask_reg + 1'b1);
    assign out_valid = |mask_reg;
    assign beat      = out_valid && out_ready;
    assign free      = (mask_reg == '0) || ($onehot(mask_reg) && out_ready);

    always_comb
    begin
        cur = '0;
        for (int i = 0; i < vlfd_pkg::NUM_SLOTS; i++)
        begin
            if (sel[i])
            begin
                cur = slot_reg[i];
            end
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (beat)
        begin
            mask_next = mask_reg & ~sel;
        end
        if (load)
        begin
            mask_next = bundle.mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg   <= bundle.slot;
            number_reg <= bundle.number;
        end
    end

    assign kind      = cur.kind;
    assign number    = number_reg;
    assign letter    = cur.letter;
    assign last_flag = cur.last_flag;
    assign overflow  = cur.overflow;

endmodule

### hdl/vlfd_checker.sv
module vlfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  opcode,
    input logic [7:0]  data_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [63:0] number,
    input logic [7:0]  letter,
    input logic        last_flag,
    input logic        overflow
);

    // A stalled input beat keeps its payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(opcode) && $stable(data_byte))
        else $error("input beat changed while stalled");

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(number)
            && $stable(letter) && $stable(last_flag) && $stable(overflow))
        else $error("output beat changed while stalled");

    a_letter_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == vlfd_pkg::KIND_LETTER |-> number == 64'd0 && !last_flag)
        else $error("letter beat carries a number or ends the field");

    a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == vlfd_pkg::KIND_END |-> last_flag && letter == 8'd0
            && number == 64'd0)
        else $error("string end beat malformed");

    a_number_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == vlfd_pkg::KIND_UNSIGNED || kind == vlfd_pkg::KIND_SIGNED)
            |-> last_flag && letter == 8'd0)
        else $error("number beat malformed");

endmodule

bind varint_and_letter_field_decoder vlfd_checker u_vlfd_checker (.*);
